// ===== rtl/lbs_pkg.sv =====
// Package for the longest bitonic subsequence block.
// Holds default parameter values and the fixed result field widths.
// No dependencies; compile first.
package lbs_pkg;

  // Default sizing of the sequence store
  localparam int DEF_MAX_ITEMS  = 64;
  localparam int DEF_DATA_WIDTH = 32;

  // Fixed widths of the result fields
  localparam int OUT_LEN_W = 7;
  localparam int OUT_IDX_W = 6;

endpackage : lbs_pkg

// ===== rtl/lbs_if.sv =====
// Valid/ready channel interfaces for the longest bitonic subsequence block.
// lbs_in_if carries sequence elements, lbs_out_if carries results.
// Depends on lbs_pkg.
interface lbs_in_if #(
  parameter int DATA_WIDTH = lbs_pkg::DEF_DATA_WIDTH
) ();
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] value;
  logic                         last;

  modport source (output valid, output value, output last, input ready);
  modport sink   (input valid, input value, input last, output ready);
endinterface : lbs_in_if

interface lbs_out_if ();
  import lbs_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [OUT_LEN_W-1:0] best_length;
  logic [OUT_IDX_W-1:0] peak_index;
  logic                 found;

  modport source (output valid, output best_length, output peak_index, output found,
                  input ready);
  modport sink   (input valid, input best_length, input peak_index, input found,
                  output ready);
endinterface : lbs_out_if

// ===== rtl/lbs_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Used for the element store and both length tables. No dependencies.
module lbs_ram #(
  parameter int  WIDTH = 32,
  parameter int  DEPTH = 64,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule : lbs_ram

// ===== rtl/longest_bitonic_subsequence_top.sv =====
// Longest bitonic subsequence: loads one element per cycle, then solves.
// Load: one transaction per cycle while collecting; after the last element the
// block is busy solving: one compare/add unit visits each earlier/later
// element once per position, one RAM read per cycle. Then one result
// transaction, then loading resumes.
// Reset (rst_n low, synchronous) empties the sequence and returns to loading.
module longest_bitonic_subsequence_top #(
  parameter int MAX_ITEMS  = lbs_pkg::DEF_MAX_ITEMS,
  parameter int DATA_WIDTH = lbs_pkg::DEF_DATA_WIDTH
) (
  input  logic      clk,
  input  logic      rst_n,
  lbs_in_if.sink    in_ch,
  lbs_out_if.source out_ch
);
  import lbs_pkg::*;

  localparam int IDX_W = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int CNT_W = $clog2(MAX_ITEMS + 1);

  typedef enum logic [7:0] {
    S_LOAD   = 8'b0000_0001,
    S_R_ADDR = 8'b0000_0010,
    S_R_LOAD = 8'b0000_0100,
    S_R_SCAN = 8'b0000_1000,
    S_F_ADDR = 8'b0001_0000,
    S_F_LOAD = 8'b0010_0000,
    S_F_SCAN = 8'b0100_0000,
    S_OUT    = 8'b1000_0000
  } state_t;

  state_t                state_r, state_nxt;
  logic [CNT_W-1:0]      count_r, count_nxt;
  logic [CNT_W-1:0]      oi_r, oi_nxt;       // outer position
  logic [CNT_W-1:0]      ji_r, ji_nxt;       // inner position being issued
  logic                  pv_r, pv_nxt;       // read data pending this cycle
  logic [CNT_W-1:0]      cur_r, cur_nxt;     // length being built for outer position
  logic [DATA_WIDTH-1:0] key_r, key_nxt;     // element at outer position
  logic [CNT_W-1:0]      rpk_r, rpk_nxt;     // rise length at peak candidate
  logic [CNT_W-1:0]      best_r, best_nxt;
  logic [IDX_W-1:0]      pos_r, pos_nxt;

  logic                  in_fire;
  logic                  elem_we, rise_we, fall_we;
  logic [IDX_W-1:0]      rd_addr;
  logic [DATA_WIDTH-1:0] elem_rd;
  logic [CNT_W-1:0]      rise_rd, fall_rd;
  logic [CNT_W-1:0]      len_rd, cand;
  logic                  hit;
  logic [CNT_W-1:0]      cur_upd;
  logic [CNT_W:0]        mount_len;

  assign in_fire = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state_r == S_LOAD);

  // Outer-position reads in address states, inner-position reads while scanning
  assign rd_addr = (state_r == S_R_ADDR || state_r == S_F_ADDR) ? oi_r[IDX_W-1:0]
                                                                : ji_r[IDX_W-1:0];

  // Shared compare/add unit: extend the running length through one element
  assign len_rd  = (state_r == S_F_SCAN) ? fall_rd : rise_rd;
  assign cand    = len_rd + CNT_W'(1);
  assign hit     = pv_r && ($signed(elem_rd) < $signed(key_r)) && (cand > cur_r);
  assign cur_upd = hit ? cand : cur_r;

  // Mountain length through the current peak candidate
  assign mount_len = {1'b0, rpk_r} + {1'b0, cur_upd} - (CNT_W + 1)'(1);

  lbs_ram #(.WIDTH(DATA_WIDTH), .DEPTH(MAX_ITEMS)) u_elem_ram (
    .clk   (clk),
    .we    (elem_we),
    .waddr (count_r[IDX_W-1:0]),
    .wdata (in_ch.value),
    .raddr (rd_addr),
    .rdata (elem_rd)
  );

  lbs_ram #(.WIDTH(CNT_W), .DEPTH(MAX_ITEMS)) u_rise_ram (
    .clk   (clk),
    .we    (rise_we),
    .waddr (oi_r[IDX_W-1:0]),
    .wdata (cur_upd),
    .raddr (rd_addr),
    .rdata (rise_rd)
  );

  lbs_ram #(.WIDTH(CNT_W), .DEPTH(MAX_ITEMS)) u_fall_ram (
    .clk   (clk),
    .we    (fall_we),
    .waddr (oi_r[IDX_W-1:0]),
    .wdata (cur_upd),
    .raddr (rd_addr),
    .rdata (fall_rd)
  );

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    oi_nxt    = oi_r;
    ji_nxt    = ji_r;
    pv_nxt    = pv_r;
    cur_nxt   = cur_r;
    key_nxt   = key_r;
    rpk_nxt   = rpk_r;
    best_nxt  = best_r;
    pos_nxt   = pos_r;
    elem_we   = 1'b0;
    rise_we   = 1'b0;
    fall_we   = 1'b0;

    case (state_r)
      S_LOAD: begin
        // Store elements until full; last starts the solve
        if (in_fire) begin
          if (count_r < CNT_W'(MAX_ITEMS)) begin
            elem_we   = 1'b1;
            count_nxt = count_r + CNT_W'(1);
          end
          if (in_ch.last) begin
            oi_nxt    = '0;
            state_nxt = S_R_ADDR;
          end
        end
      end

      S_R_ADDR: begin
        state_nxt = S_R_LOAD;
      end

      S_R_LOAD: begin
        key_nxt   = elem_rd;
        cur_nxt   = CNT_W'(1);
        ji_nxt    = '0;
        pv_nxt    = 1'b0;
        state_nxt = S_R_SCAN;
      end

      S_R_SCAN: begin
        // Issue earlier positions, fold in returned data, then write rise length
        cur_nxt = cur_upd;
        if (ji_r < oi_r) begin
          ji_nxt = ji_r + CNT_W'(1);
          pv_nxt = 1'b1;
        end else begin
          rise_we = 1'b1;
          pv_nxt  = 1'b0;
          if (oi_r + CNT_W'(1) == count_r) begin
            oi_nxt    = count_r - CNT_W'(1);
            best_nxt  = '0;
            pos_nxt   = '0;
            state_nxt = S_F_ADDR;
          end else begin
            oi_nxt    = oi_r + CNT_W'(1);
            state_nxt = S_R_ADDR;
          end
        end
      end

      S_F_ADDR: begin
        state_nxt = S_F_LOAD;
      end

      S_F_LOAD: begin
        key_nxt   = elem_rd;
        rpk_nxt   = rise_rd;
        cur_nxt   = CNT_W'(1);
        ji_nxt    = count_r - CNT_W'(1);
        pv_nxt    = 1'b0;
        state_nxt = S_F_SCAN;
      end

      S_F_SCAN: begin
        // Issue later positions from the right, then write fall length and score peak
        cur_nxt = cur_upd;
        if (ji_r > oi_r) begin
          ji_nxt = ji_r - CNT_W'(1);
          pv_nxt = 1'b1;
        end else begin
          fall_we = 1'b1;
          pv_nxt  = 1'b0;
          if (rpk_r > CNT_W'(1) && cur_upd > CNT_W'(1) && mount_len > {1'b0, best_r}) begin
            best_nxt = mount_len[CNT_W-1:0];
            pos_nxt  = oi_r[IDX_W-1:0];
          end
          if (oi_r == '0) begin
            state_nxt = S_OUT;
          end else begin
            oi_nxt    = oi_r - CNT_W'(1);
            state_nxt = S_F_ADDR;
          end
        end
      end

      S_OUT: begin
        // Hold the result until taken, then start a new sequence
        if (out_ch.ready) begin
          count_nxt = '0;
          state_nxt = S_LOAD;
        end
      end

      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
      count_r <= '0;
      pv_r    <= 1'b0;
      best_r  <= '0;
      pos_r   <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      pv_r    <= pv_nxt;
      best_r  <= best_nxt;
      pos_r   <= pos_nxt;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    oi_r  <= oi_nxt;
    ji_r  <= ji_nxt;
    cur_r <= cur_nxt;
    key_r <= key_nxt;
    rpk_r <= rpk_nxt;
  end

  // Result channel
  assign out_ch.valid       = (state_r == S_OUT);
  assign out_ch.best_length = OUT_LEN_W'(best_r);
  assign out_ch.peak_index  = OUT_IDX_W'(pos_r);
  assign out_ch.found       = (best_r != '0);

endmodule : longest_bitonic_subsequence_top

// ===== verif/longest_bitonic_subsequence_top_tb.sv =====
// Self-checking testbench for longest_bitonic_subsequence_top.
// Drives sequences of signed elements and checks every mountain result against
// a typed expectation or a predictor of its own. Depends on lbs_pkg, lbs_if.sv and the top-level RTL.
module longest_bitonic_subsequence_top_tb;
  import lbs_pkg::*;

  localparam int NUM_ROWS       = 22;
  localparam int ITEM_TARGET    = 1000;
  localparam int REPORT_LIMIT   = 10;
  localparam int LONG_HOLD      = 300;
  // Quiet-cycle limit, well above the length of a full-store solve.
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int SETTLE_CYCLES  = 64;

  localparam logic signed [DEF_DATA_WIDTH-1:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [DEF_DATA_WIDTH-1:0] VAL_MAX = 32'sh7FFF_FFFF;

  typedef struct packed {
    logic [OUT_LEN_W-1:0] best_length;
    logic [OUT_IDX_W-1:0] peak_index;
    logic                 found;
  } mountain_t;

  typedef struct packed {
    logic signed [DEF_DATA_WIDTH-1:0] value;
    logic                             last;
    logic                             typed;
    logic [OUT_LEN_W-1:0]             len;
    logic [OUT_IDX_W-1:0]             idx;
    logic                             fnd;
  } stim_row_t;

  typedef enum int {SHAPE_WIDE, SHAPE_NARROW, SHAPE_MOUNTAIN, SHAPE_EXTREME} shape_t;

  logic clk;
  logic rst_n;

  lbs_in_if #(.DATA_WIDTH(DEF_DATA_WIDTH)) in_ch ();
  lbs_out_if out_ch ();

  longest_bitonic_subsequence_top #(
    .MAX_ITEMS (DEF_MAX_ITEMS),
    .DATA_WIDTH(DEF_DATA_WIDTH)
  ) dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  // Elements of the open sequence and mountains still owed by the block
  logic signed [DEF_DATA_WIDTH-1:0] held_elements[$];
  mountain_t                        pending_mountains[$];
  int                               mismatch_count = 0;
  int                               items_sent     = 0;
  bit                               sender_calm    = 1'b0;

  // Directed sequences; typed expectations only where obvious
  stim_row_t directed_rows [NUM_ROWS] = '{
    // lone element: nothing to climb
    '{32'sd5,       1'b1, 1'b1, 7'd0, 6'd0, 1'b0},
    // plain mountain
    '{32'sd1,       1'b0, 1'b0, 7'd0, 6'd0, 1'b0},
    '{32'sd3,       1'b0, 1'b0, 7'd0, 6'd0, 1'b0},
    '{32'sd2,       1'b1, 1'b1, 7'd3, 6'd1, 1'b1},
    // extremes: most negative, most positive, most negative
    '{VAL_MIN,      1'b0, 1'b0, 7'd0, 6'd0, 1'b0},
    '{VAL_MAX,      1'b0, 1'b0, 7'd0, 6'd0, 1'b0},
    '{VAL_MIN,      1'b1, 1'b1, 7'd3, 6'd1, 1'b1},
    // strictly rising across zero: no fall, no mountain
    '{-32'sd1,      1'b0, 1'b0, 7'd0, 6'd0, 1'b0},
    '{32'sd0,       1'b0, 1'b0, 7'd0, 6'd0, 1'b0},
    '{32'sd1,       1'b1, 1'b1, 7'd0, 6'd0, 1'b0},
    // flat run: equal values never rise
    '{32'sd7,       1'b0, 1'b0, 7'd0, 6'd0, 1'b0},
    '{32'sd7,       1'b0, 1'b0, 7'd0, 6'd0, 1'b0},
    '{32'sd7,       1'b1, 1'b1, 7'd0, 6'd0, 1'b0},
    // twin peaks of equal length: the higher index wins
    '{32'sd1,       1'b0, 1'b0, 7'd0, 6'd0, 1'b0},
    '{32'sd2,       1'b0, 1'b0, 7'd0, 6'd0, 1'b0},
    '{32'sd1,       1'b0, 1'b0, 7'd0, 6'd0, 1'b0},
    '{32'sd2,       1'b0, 1'b0, 7'd0, 6'd0, 1'b0},
    '{32'sd1,       1'b1, 1'b1, 7'd3, 6'd3, 1'b1},
    // mixed signs, left to the predictor
    '{32'sd3,       1'b0, 1'b0, 7'd0, 6'd0, 1'b0},
    '{-32'sd2,      1'b0, 1'b0, 7'd0, 6'd0, 1'b0},
    '{32'sd9,       1'b0, 1'b0, 7'd0, 6'd0, 1'b0},
    '{32'sd4,       1'b1, 1'b0, 7'd0, 6'd0, 1'b0}
  };

  // Clock
  initial clk = 1'b0;
  always #4 clk = ~clk;

  // Longest mountain over the held elements; the right-to-left scan keeps
  // the peak at the highest index on ties
  function automatic mountain_t solve_mountain();
    int        n;
    int        rise [DEF_MAX_ITEMS];
    int        fall [DEF_MAX_ITEMS];
    int        best;
    int        pos;
    mountain_t m;
    n    = held_elements.size();
    best = 0;
    pos  = 0;
    for (int i = 0; i < n; i++) begin
      rise[i] = 1;
      for (int j = 0; j < i; j++) begin
        if (held_elements[j] < held_elements[i] && rise[j] + 1 > rise[i]) begin
          rise[i] = rise[j] + 1;
        end
      end
    end
    for (int p = n - 1; p >= 0; p--) begin
      fall[p] = 1;
      for (int j = n - 1; j > p; j--) begin
        if (held_elements[j] < held_elements[p] && fall[j] + 1 > fall[p]) begin
          fall[p] = fall[j] + 1;
        end
      end
      if (rise[p] > 1 && fall[p] > 1 && rise[p] + fall[p] - 1 > best) begin
        best = rise[p] + fall[p] - 1;
        pos  = p;
      end
    end
    m.best_length = OUT_LEN_W'(best);
    m.peak_index  = OUT_IDX_W'(pos);
    m.found       = (best > 0);
    return m;
  endfunction

  // Offer one element after a random gap (none when calm), hold it until the transaction,
  // then record it and owe a mountain on the last mark
  task automatic load_element(input logic signed [DEF_DATA_WIDTH-1:0] v, input logic l,
                              input logic typed, input mountain_t want);
    int gap;
    gap = sender_calm ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.value <= v;
    in_ch.last  <= l;
    do @(posedge clk); while (!(in_ch.valid && in_ch.ready));
    items_sent++;
    // Drop elements once the store is full; the last mark still solves
    if (held_elements.size() < DEF_MAX_ITEMS) held_elements.push_back(v);
    if (l) begin
      pending_mountains.push_back(typed ? want : solve_mountain());
      held_elements.delete();
    end
  endtask

  // Sender: directed table, then random sequences
  initial begin : stimulus
    int                               len;
    int                               peak;
    int                               base;
    int                               seq_idx;
    int                               pick;
    bit                               noisy;
    shape_t                           shape;
    logic signed [DEF_DATA_WIDTH-1:0] v;
    rst_n       = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.value = '0;
    in_ch.last  = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[k]) begin
      load_element(directed_rows[k].value, directed_rows[k].last, directed_rows[k].typed,
                   {directed_rows[k].len, directed_rows[k].idx, directed_rows[k].fnd});
    end

    seq_idx = 0;
    while (items_sent < ITEM_TARGET) begin
      // Mostly short sequences; a few fill the store or overflow it
      pick = $urandom_range(0, 99);
      if (pick < 85)      len = $urandom_range(1, 12);
      else if (pick < 95) len = $urandom_range(13, 63);
      else if (pick < 98) len = DEF_MAX_ITEMS;
      else                len = $urandom_range(DEF_MAX_ITEMS + 1, DEF_MAX_ITEMS + 8);
      pick = $urandom_range(0, 99);
      if (pick < 25)      shape = SHAPE_WIDE;
      else if (pick < 50) shape = SHAPE_NARROW;
      else if (pick < 85) shape = SHAPE_MOUNTAIN;
      else                shape = SHAPE_EXTREME;
      noisy = 1'b1;
      // Force a clean full-length mountain and one overflowing sequence
      if (seq_idx == 3) begin
        len   = DEF_MAX_ITEMS;
        shape = SHAPE_MOUNTAIN;
        noisy = 1'b0;
      end
      if (seq_idx == 7) len = DEF_MAX_ITEMS + 6;
      peak = (len > 2) ? $urandom_range(1, len - 2) : 0;
      if (seq_idx == 3) peak = $urandom_range(1, DEF_MAX_ITEMS - 2);
      base = int'($urandom_range(0, 2000000)) - 1000000;
      sender_calm = ($urandom_range(0, 3) == 0);

      // Stop offering until the block has returned everything owed
      if (seq_idx == 20) begin
        in_ch.valid <= 1'b0;
        while (pending_mountains.size() != 0) @(posedge clk);
      end

      for (int p = 0; p < len; p++) begin
        case (shape)
          SHAPE_WIDE:   v = $urandom;
          SHAPE_NARROW: v = int'($urandom_range(0, 8)) - 4;
          SHAPE_MOUNTAIN: begin
            if (p <= peak) v = base + p * 4;
            else           v = base + peak * 4 - (p - peak) * 3;
            if (noisy && $urandom_range(0, 7) == 0) v = base + int'($urandom_range(0, 200));
          end
          default: begin
            case ($urandom_range(0, 6))
              0:       v = VAL_MIN;
              1:       v = VAL_MIN + 1;
              2:       v = -1;
              3:       v = 0;
              4:       v = 1;
              5:       v = VAL_MAX - 1;
              default: v = VAL_MAX;
            endcase
          end
        endcase
        load_element(v, p == len - 1, 1'b0, '0);
      end
      seq_idx++;
    end
    in_ch.valid <= 1'b0;

    // Drain, then watch for stray results
    while (pending_mountains.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_mountains.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Receiver: random stalls, calm stretches, one long hold-off
  initial begin : receiver
    int stall;
    int served;
    bit calm;
    out_ch.ready = 1'b0;
    served       = 0;
    calm         = 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (served % 20 == 0) calm = ($urandom_range(0, 3) == 0);
      stall = calm ? 0 : $urandom_range(0, 11);
      if (served == 15) stall = LONG_HOLD;
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!(out_ch.valid && out_ch.ready));
      served++;
    end
  end

  // Compare each result transaction with the oldest owed mountain
  always @(posedge clk) begin : result_check
    mountain_t want;
    if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (pending_mountains.size() == 0) begin
        if (mismatch_count < REPORT_LIMIT) begin
          $display("unexpected result: len %0d peak %0d found %0d",
                   out_ch.best_length, out_ch.peak_index, out_ch.found);
        end
        mismatch_count++;
      end else begin
        want = pending_mountains.pop_front();
        if (out_ch.best_length !== want.best_length || out_ch.peak_index !== want.peak_index
            || out_ch.found !== want.found) begin
          if (mismatch_count < REPORT_LIMIT) begin
            $display("mismatch: exp len %0d peak %0d found %0d, got len %0d peak %0d found %0d",
                     want.best_length, want.peak_index, want.found,
                     out_ch.best_length, out_ch.peak_index, out_ch.found);
          end
          mismatch_count++;
        end
      end
    end
  end

  // End the run when no transaction happens for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet = 0;
      else quiet++;
    end
    $display("timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule : longest_bitonic_subsequence_top_tb
